FILE: rtl/ikin_pkg.sv
// Package: word types, angle constants and arctangent table for the arm solver.
`timescale 1ns / 1ps
`default_nettype none
package ikin_pkg;

    localparam int ZW        = 30;
    localparam int ANG_FRAC  = 20;
    localparam int TAB_LEN   = 24;
    localparam int OUT_W     = 19;

    localparam logic signed [ZW-1:0] DEG90  = ZW'(90) <<< ANG_FRAC;
    localparam logic signed [ZW-1:0] DEG180 = ZW'(180) <<< ANG_FRAC;
    localparam logic signed [ZW-1:0] DEG360 = ZW'(360) <<< ANG_FRAC;

    typedef struct packed {
        logic signed [15:0] target_x;
        logic signed [15:0] target_y;
    } t_in;

    typedef struct packed {
        logic [OUT_W-1:0] base_angle_anti;
        logic [OUT_W-1:0] elbow_angle_anti;
        logic             anti_reachable;
        logic [OUT_W-1:0] base_angle_clock;
        logic [OUT_W-1:0] elbow_angle_clock;
        logic             clock_reachable;
    } t_out;

    typedef struct packed {
        logic        unreach;
        logic        x_neg;
        logic        y_neg;
        logic        ax_zero;
        logic        ay_zero;
        logic [15:0] ax;
        logic [15:0] ay;
    } t_geo;

    typedef struct packed {
        logic unreach;
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } t_quad;

    function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
        logic signed [ZW-1:0] v;
        case (idx)
            5'd0:    v = ZW'(47185920);
            5'd1:    v = ZW'(27855475);
            5'd2:    v = ZW'(14718068);
            5'd3:    v = ZW'(7471121);
            5'd4:    v = ZW'(3750058);
            5'd5:    v = ZW'(1876857);
            5'd6:    v = ZW'(938658);
            5'd7:    v = ZW'(469357);
            5'd8:    v = ZW'(234682);
            5'd9:    v = ZW'(117342);
            5'd10:   v = ZW'(58671);
            5'd11:   v = ZW'(29335);
            5'd12:   v = ZW'(14668);
            5'd13:   v = ZW'(7334);
            5'd14:   v = ZW'(3667);
            5'd15:   v = ZW'(1833);
            5'd16:   v = ZW'(917);
            5'd17:   v = ZW'(458);
            5'd18:   v = ZW'(229);
            5'd19:   v = ZW'(115);
            5'd20:   v = ZW'(57);
            5'd21:   v = ZW'(29);
            5'd22:   v = ZW'(14);
            5'd23:   v = ZW'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/ikin_sqrt.sv
// Two-lane pipelined integer square root, one root bit per stage, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module ikin_sqrt
    import ikin_pkg::*;
#(
    parameter int IW  = 48,
    parameter int SBW = 37
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [IW-1:0]  i_a,
    input  wire logic [IW-1:0]  i_b,
    input  wire logic [SBW-1:0] i_sb,
    output logic                o_valid,
    output logic [IW/2-1:0]     o_root_a,
    output logic [IW/2-1:0]     o_root_b,
    output logic [SBW-1:0]      o_sb
);
    localparam int K  = IW / 2;
    localparam int RW = K + 3;

    logic          r_vld  [0:K-1];
    logic [SBW-1:0] r_sb  [0:K-1];
    logic [RW-1:0] r_rema [0:K-1];
    logic [RW-1:0] r_remb [0:K-1];
    logic [K-1:0]  r_qa   [0:K-1];
    logic [K-1:0]  r_qb   [0:K-1];
    logic [IW-1:0] r_va   [0:K-1];
    logic [IW-1:0] r_vb   [0:K-1];

    for (genvar k = 0; k < K; k++) begin : g_st
        logic           a_vld;
        logic [SBW-1:0] a_sb;
        logic [RW-1:0]  a_rema, a_remb, n_rem2a, n_rem2b, n_trya, n_tryb;
        logic [K-1:0]   a_qa, a_qb;
        logic [IW-1:0]  a_va, a_vb;

        if (k == 0) begin : g_src
            assign a_vld  = i_valid;
            assign a_sb   = i_sb;
            assign a_rema = '0;
            assign a_remb = '0;
            assign a_qa   = '0;
            assign a_qb   = '0;
            assign a_va   = i_a;
            assign a_vb   = i_b;
        end else begin : g_src
            assign a_vld  = r_vld[k-1];
            assign a_sb   = r_sb[k-1];
            assign a_rema = r_rema[k-1];
            assign a_remb = r_remb[k-1];
            assign a_qa   = r_qa[k-1];
            assign a_qb   = r_qb[k-1];
            assign a_va   = r_va[k-1];
            assign a_vb   = r_vb[k-1];
        end

        assign n_rem2a = {a_rema[RW-3:0], a_va[IW-1 -: 2]};
        assign n_rem2b = {a_remb[RW-3:0], a_vb[IW-1 -: 2]};
        assign n_trya  = RW'({a_qa, 2'b01});
        assign n_tryb  = RW'({a_qb, 2'b01});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sb[k] <= a_sb;
            r_va[k] <= a_va << 2;
            r_vb[k] <= a_vb << 2;
            if (n_rem2a >= n_trya) begin
                r_rema[k] <= n_rem2a - n_trya;
                r_qa[k]   <= {a_qa[K-2:0], 1'b1};
            end else begin
                r_rema[k] <= n_rem2a;
                r_qa[k]   <= {a_qa[K-2:0], 1'b0};
            end
            if (n_rem2b >= n_tryb) begin
                r_remb[k] <= n_rem2b - n_tryb;
                r_qb[k]   <= {a_qb[K-2:0], 1'b1};
            end else begin
                r_remb[k] <= n_rem2b;
                r_qb[k]   <= {a_qb[K-2:0], 1'b0};
            end
        end
    end

    assign o_valid  = r_vld[K-1];
    assign o_root_a = r_qa[K-1];
    assign o_root_b = r_qb[K-1];
    assign o_sb     = r_sb[K-1];
endmodule
`default_nettype wire

FILE: rtl/ikin_cordic.sv
// Pipelined vectoring CORDIC arctangent in degrees, clamped to 0..90, with sideband.
`timescale 1ns / 1ps
`default_nettype none
module ikin_cordic
    import ikin_pkg::*;
#(
    parameter int W      = 32,
    parameter int STAGES = 18,
    parameter int SBW    = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic signed [W-1:0]  i_x,
    input  wire logic signed [W-1:0]  i_y,
    input  wire logic [SBW-1:0]       i_sb,
    output logic                      o_valid,
    output logic signed [ZW-1:0]      o_angle,
    output logic [SBW-1:0]            o_sb
);
    logic                  r_vld [0:STAGES-1];
    logic [SBW-1:0]        r_sb  [0:STAGES-1];
    logic signed [W-1:0]   r_x   [0:STAGES-1];
    logic signed [W-1:0]   r_y   [0:STAGES-1];
    logic signed [ZW-1:0]  r_z   [0:STAGES-1];

    for (genvar k = 0; k < STAGES; k++) begin : g_st
        logic                 a_vld;
        logic [SBW-1:0]       a_sb;
        logic signed [W-1:0]  a_x, a_y, n_xs, n_ys;
        logic signed [ZW-1:0] a_z;

        if (k == 0) begin : g_src
            assign a_vld = i_valid;
            assign a_sb  = i_sb;
            assign a_x   = i_x;
            assign a_y   = i_y;
            assign a_z   = '0;
        end else begin : g_src
            assign a_vld = r_vld[k-1];
            assign a_sb  = r_sb[k-1];
            assign a_x   = r_x[k-1];
            assign a_y   = r_y[k-1];
            assign a_z   = r_z[k-1];
        end

        assign n_xs = a_x >>> k;
        assign n_ys = a_y >>> k;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= a_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            r_sb[k] <= a_sb;
            if (!a_y[W-1]) begin
                r_x[k] <= a_x + n_ys;
                r_y[k] <= a_y - n_xs;
                r_z[k] <= a_z + atan_tab(5'(k));
            end else begin
                r_x[k] <= a_x - n_ys;
                r_y[k] <= a_y + n_xs;
                r_z[k] <= a_z - atan_tab(5'(k));
            end
        end
    end

    always_comb begin
        if (r_z[STAGES-1] < 0) begin
            o_angle = '0;
        end else if (r_z[STAGES-1] > DEG90) begin
            o_angle = DEG90;
        end else begin
            o_angle = r_z[STAGES-1];
        end
    end

    assign o_valid = r_vld[STAGES-1];
    assign o_sb    = r_sb[STAGES-1];
endmodule
`default_nettype wire

FILE: rtl/two_link_arm_inverse_kinematics_top.sv
// Top level: two-link equal-arm inverse kinematics pipeline.
//
// Takes one target point per clock; busy is always low and never holds off start.
// Each word leaves on o_result with a one-cycle o_done strobe after the square,
// reach and stretch registers, the square-root pipeline of root width K (half of
// the even width of max(32, 2*COORD_FRAC_BITS+3)+16, 24 at the default), the two
// CORDIC pipelines with STAGES = min(CORDIC_STAGES, 24), and the angle, solution
// and rounding registers. Throughput is one word per cycle.
// The receiver cannot stall, so results are presented once and not held.
`timescale 1ns / 1ps
`default_nettype none
module two_link_arm_inverse_kinematics_top
    import ikin_pkg::*;
#(
    parameter int COORD_FRAC_BITS = 13,
    parameter int CORDIC_STAGES   = 18
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_in  i_target,
    output logic      o_done,
    output t_out      o_result
);
    localparam int S    = (CORDIC_STAGES > TAB_LEN) ? TAB_LEN : CORDIC_STAGES;
    localparam int LW0  = 2 * COORD_FRAC_BITS + 3;
    localparam int LW   = (LW0 > 32) ? LW0 : 32;
    localparam int IW   = LW + 16 + ((LW + 16) % 2);
    localparam int K    = IW / 2;
    localparam int HW   = K + 3;
    localparam logic [LW-1:0] LIM = LW'(4) << (2 * COORD_FRAC_BITS);

    assign busy = 1'b0;

    // square and capture
    logic               r1_vld;
    logic signed [15:0] r1_x, r1_y;
    logic [31:0]        r1_xx, r1_yy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= start & ~busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x  <= i_target.target_x;
        r1_y  <= i_target.target_y;
        r1_xx <= 32'(i_target.target_x * i_target.target_x);
        r1_yy <= 32'(i_target.target_y * i_target.target_y);
    end

    // radius squared, reach and quadrant
    logic [LW-1:0] n2_r2;
    logic          r2_vld;
    logic [LW-1:0] r2_r2;
    t_geo          r2_geo;

    assign n2_r2 = LW'(r1_xx) + LW'(r1_yy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else begin
            r2_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_r2           <= n2_r2;
        r2_geo.unreach  <= (n2_r2 == '0) || (n2_r2 > LIM);
        r2_geo.x_neg    <= r1_x[15];
        r2_geo.y_neg    <= r1_y[15];
        r2_geo.ax_zero  <= (r1_x == '0);
        r2_geo.ay_zero  <= (r1_y == '0);
        r2_geo.ax       <= r1_x[15] ? 16'(-r1_x) : 16'(r1_x);
        r2_geo.ay       <= r1_y[15] ? 16'(-r1_y) : 16'(r1_y);
    end

    // remaining squared length to full stretch
    logic          r3_vld;
    logic [LW-1:0] r3_r2, r3_d;
    t_geo          r3_geo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_r2  <= r2_r2;
        r3_d   <= LIM - r2_r2;
        r3_geo <= r2_geo;
    end

    logic          sq_vld;
    logic [K-1:0]  sq_r, sq_s;
    t_geo          sq_geo;

    ikin_sqrt #(
        .IW  (IW),
        .SBW ($bits(t_geo))
    ) u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r3_vld),
        .i_a      (IW'({r3_r2, 16'b0})),
        .i_b      (IW'({r3_d, 16'b0})),
        .i_sb     (r3_geo),
        .o_valid  (sq_vld),
        .o_root_a (sq_r),
        .o_root_b (sq_s),
        .o_sb     (sq_geo)
    );

    t_quad              sq_quad;
    logic signed [31:0] base_px, base_py;
    logic signed [HW-1:0] half_px, half_py;

    assign sq_quad.unreach = sq_geo.unreach;
    assign sq_quad.x_neg   = sq_geo.x_neg;
    assign sq_quad.y_neg   = sq_geo.y_neg;
    assign sq_quad.ax_zero = sq_geo.ax_zero;
    assign sq_quad.ay_zero = sq_geo.ay_zero;
    assign base_px = $signed({4'b0, sq_geo.ax, 12'b0});
    assign base_py = $signed({4'b0, sq_geo.ay, 12'b0});
    assign half_px = $signed({3'b0, sq_r});
    assign half_py = $signed({3'b0, sq_s});

    logic                 cb_vld;
    logic signed [ZW-1:0] cb_ang;
    t_quad                cb_quad;
    logic                 ch_vld;
    logic signed [ZW-1:0] ch_ang;
    logic                 ch_szero;

    ikin_cordic #(
        .W      (32),
        .STAGES (S),
        .SBW    ($bits(t_quad))
    ) u_cordic_base (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_x     (base_px),
        .i_y     (base_py),
        .i_sb    (sq_quad),
        .o_valid (cb_vld),
        .o_angle (cb_ang),
        .o_sb    (cb_quad)
    );

    ikin_cordic #(
        .W      (HW),
        .STAGES (S),
        .SBW    (1)
    ) u_cordic_half (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sq_vld),
        .i_x     (half_px),
        .i_y     (half_py),
        .i_sb    (sq_s == '0),
        .o_valid (ch_vld),
        .o_angle (ch_ang),
        .o_sb    (ch_szero)
    );

    // base direction and half elbow
    logic signed [ZW-1:0] n4_a, n4_phi;
    logic                 r4_vld, r4_unreach;
    logic signed [ZW-1:0] r4_phi, r4_half;

    always_comb begin
        if (cb_quad.ay_zero) begin
            n4_a = '0;
        end else if (cb_quad.ax_zero) begin
            n4_a = DEG90;
        end else begin
            n4_a = cb_ang;
        end
        case ({cb_quad.x_neg, cb_quad.y_neg})
            2'b00:   n4_phi = n4_a;
            2'b10:   n4_phi = DEG180 - n4_a;
            2'b11:   n4_phi = DEG180 + n4_a;
            default: n4_phi = DEG360 - n4_a;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else begin
            r4_vld <= cb_vld & ch_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r4_unreach <= cb_quad.unreach;
        r4_phi     <= n4_phi;
        r4_half    <= ch_szero ? '0 : ch_ang;
    end

    // both solutions
    logic                 r5_vld, r5_unreach;
    logic signed [ZW-1:0] r5_anti, r5_clock, r5_elbow;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
        end else begin
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_unreach <= r4_unreach;
        r5_anti    <= r4_phi - r4_half;
        r5_clock   <= r4_phi + r4_half;
        r5_elbow   <= r4_half <<< 1;
    end

    // range check and rounding
    logic                 n6_anti_ok, n6_clock_ok;
    logic signed [ZW-1:0] n6_anti_rnd, n6_clock_rnd, n6_elbow_rnd;
    logic                 r6_done;
    t_out                 r6_res;

    assign n6_anti_ok   = !r5_unreach && (r5_anti >= 0) && (r5_anti <= DEG360);
    assign n6_clock_ok  = !r5_unreach && (r5_clock >= 0) && (r5_clock <= DEG360);
    assign n6_anti_rnd  = r5_anti + ZW'(512);
    assign n6_clock_rnd = r5_clock + ZW'(512);
    assign n6_elbow_rnd = r5_elbow + ZW'(512);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_done <= 1'b0;
        end else begin
            r6_done <= r5_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r6_res.anti_reachable    <= n6_anti_ok;
        r6_res.base_angle_anti   <= n6_anti_ok ? n6_anti_rnd[10 +: OUT_W] : '0;
        r6_res.elbow_angle_anti  <= n6_anti_ok ? n6_elbow_rnd[10 +: OUT_W] : '0;
        r6_res.clock_reachable   <= n6_clock_ok;
        r6_res.base_angle_clock  <= n6_clock_ok ? n6_clock_rnd[10 +: OUT_W] : '0;
        r6_res.elbow_angle_clock <= n6_clock_ok ? n6_elbow_rnd[10 +: OUT_W] : '0;
    end

    assign o_done   = r6_done;
    assign o_result = r6_res;
endmodule
`default_nettype wire

FILE: rtl/ikin_checker.sv
// Checker on the top-level ports, bound to the arm solver.
`timescale 1ns / 1ps
`default_nettype none
module ikin_checker
    import ikin_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic busy,
    input wire logic o_done,
    input wire t_out o_result
);
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("busy raised");

    a_anti_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.anti_reachable) |->
        (o_result.base_angle_anti == '0 && o_result.elbow_angle_anti == '0))
        else $error("unreachable anticlockwise word carries angles");

    a_clock_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.clock_reachable) |->
        (o_result.base_angle_clock == '0 && o_result.elbow_angle_clock == '0))
        else $error("unreachable clockwise word carries angles");

    a_elbow_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.anti_reachable && o_result.clock_reachable) |->
        (o_result.elbow_angle_anti == o_result.elbow_angle_clock
         && o_result.elbow_angle_anti <= OUT_W'(184320)))
        else $error("elbow angles disagree or exceed half turn");
endmodule

bind two_link_arm_inverse_kinematics_top ikin_checker u_ikin_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
`default_nettype wire
